// File: rtl/sovc_pkg.sv
// sovc_pkg: shared types and constants of the symmetric overlay colormap
// no dependencies
package sovc_pkg;

   localparam int Q_BITS     = 32;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = Q_BITS / DIV_STEP;

   typedef enum logic [2:0] {
      CSR_MIN_POINT    = 3'd0,
      CSR_MID_POINT    = 3'd1,
      CSR_MAX_POINT    = 3'd2,
      CSR_VALUE_OFFSET = 3'd3,
      CSR_OPACITY      = 3'd4,
      CSR_LOW_COLOUR   = 3'd5,
      CSR_HIGH_COLOUR  = 3'd6,
      CSR_CONTROL      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      METHOD_OPAQUE    = 2'd0,
      METHOD_LINEAR    = 2'd1,
      METHOD_PIECEWISE = 2'd2,
      METHOD_NONE      = 2'd3
   } method_type;

   typedef enum logic [1:0] {
      SEG_LOW  = 2'd0,
      SEG_HIGH = 2'd1,
      SEG_HOLD = 2'd2
   } seg_type;

   localparam int CTL_INVERSE  = 2;
   localparam int CTL_TRUNCATE = 3;
   localparam int CTL_MASK_ON  = 4;
   localparam int CTL_MASK_INV = 5;

   localparam logic [8:0] OPACITY_FULL = 9'd256;

   typedef logic [2:0][7:0] rgb_type;

   typedef struct packed {
      rgb_type    a;
      rgb_type    b;
      rgb_type    base;
      logic [8:0] op;
      logic       painted;
      logic       full;
   } pix_type;

endpackage

// File: rtl/sovc_if.sv
// sovc_req_if and sovc_rsp_if: valid/ready channels of the colormap
// no dependencies
interface sovc_req_if #(parameter int VALUE_WIDTH = 32);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] sample_value;
   logic [7:0]             base_red;
   logic [7:0]             base_green;
   logic [7:0]             base_blue;
   logic                   mask_bit;
   logic                   mask_applies;
   modport source (output valid, sample_value, base_red, base_green, base_blue,
                   mask_bit, mask_applies, input ready);
   modport sink (input valid, sample_value, base_red, base_green, base_blue,
                 mask_bit, mask_applies, output ready);
endinterface

interface sovc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       painted;
   modport source (output valid, out_red, out_green, out_blue, painted, input ready);
   modport sink (input valid, out_red, out_green, out_blue, painted, output ready);
endinterface

// File: rtl/symmetric_overlay_colormap.sv
// symmetric_overlay_colormap: threshold test, ramp ratio, blend, per vertex
// uses sovc_pkg, sovc_if and sovc_div_step
//
//  channel  direction  payload
//  req      in         sample_value, base_red/green/blue, mask_bit, mask_applies
//  rsp      out        out_red/green/blue, painted
//  csr      in         csr_wr_en, csr_index, csr_wr_data
//
// one vertex per cycle while the output is not stalled; 3 classify stages, 8 divider
// stages of 4 quotient bits each, 2 multiply stages
// each stage holds when the next is full and stalled; bubbles collapse
// reset clears valid bits and loads register reset values
module symmetric_overlay_colormap #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   sovc_req_if.sink               req,
   sovc_rsp_if.source             rsp,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [((VALUE_WIDTH > 24) ? VALUE_WIDTH : 24)-1:0] csr_wr_data
);
   localparam int W  = VALUE_WIDTH;
   localparam int NW = VALUE_WIDTH + 4;
   localparam int ND = sovc_pkg::DIV_STAGES;
   localparam int NS = ND + 5;
   localparam logic [W-1:0] MAX_RESET = W'(1) << FRACTION_BITS;

   // configuration
   logic [W-1:0] min_ff, mid_ff, max_ff, off_ff;
   logic [8:0]   opacity_ff;
   logic [23:0]  low_ff, high_ff;
   logic [5:0]   control_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= '0;
         mid_ff     <= '0;
         max_ff     <= MAX_RESET;
         off_ff     <= '0;
         opacity_ff <= sovc_pkg::OPACITY_FULL;
         low_ff     <= 24'hFF0000;
         high_ff    <= 24'hFFFF00;
         control_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (sovc_pkg::csr_index_type'(csr_index))
            sovc_pkg::CSR_MIN_POINT:    min_ff     <= csr_wr_data[W-1:0];
            sovc_pkg::CSR_MID_POINT:    mid_ff     <= csr_wr_data[W-1:0];
            sovc_pkg::CSR_MAX_POINT:    max_ff     <= csr_wr_data[W-1:0];
            sovc_pkg::CSR_VALUE_OFFSET: off_ff     <= csr_wr_data[W-1:0];
            sovc_pkg::CSR_OPACITY:      opacity_ff <= csr_wr_data[8:0];
            sovc_pkg::CSR_LOW_COLOUR:   low_ff     <= csr_wr_data[23:0];
            sovc_pkg::CSR_HIGH_COLOUR:  high_ff    <= csr_wr_data[23:0];
            sovc_pkg::CSR_CONTROL:      control_ff <= csr_wr_data[5:0];
            default: ;
         endcase
      end
   end

   function automatic logic signed [NW-1:0] ext1(input logic [W-1:0] x);
      return {{4{x[W-1]}}, x};
   endfunction

   function automatic logic signed [NW-1:0] ext2(input logic [W-1:0] x);
      return {{3{x[W-1]}}, x, 1'b0};
   endfunction

   function automatic sovc_pkg::rgb_type unpack(input logic [23:0] c, input logic swap);
      sovc_pkg::rgb_type ch;
      ch[0] = swap ? c[7:0] : c[23:16];
      ch[1] = c[15:8];
      ch[2] = swap ? c[23:16] : c[7:0];
      return ch;
   endfunction

   sovc_pkg::method_type method;
   logic signed [NW-1:0] min2, max2, off2, mid2;
   logic inv, trunc;
   assign method = sovc_pkg::method_type'(control_ff[1:0]);
   assign inv    = control_ff[sovc_pkg::CTL_INVERSE];
   assign trunc  = control_ff[sovc_pkg::CTL_TRUNCATE];
   assign min2   = ext2(min_ff);
   assign max2   = ext2(max_ff);
   assign off2   = ext2(off_ff);
   assign mid2   = (method == sovc_pkg::METHOD_PIECEWISE) ? ext2(mid_ff)
                                                          : ext1(max_ff) + ext1(min_ff);

   // stall chain
   logic [NS-1:0] valid_ff;
   logic [NS:0]   en;
   always_comb begin
      en[NS] = rsp.ready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end
   assign req.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= req.valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // stage 1: threshold tests
   logic signed [NW-1:0] d2_in, d2_ff;
   logic hit_pos, hit_neg, inmask, painted1_in, in_low, in_high;
   logic pos_ff, swap_ff, painted1_ff;
   sovc_pkg::seg_type    seg_in, seg_ff;
   sovc_pkg::rgb_type    base1_ff;
   logic [8:0]           op1_ff;

   assign d2_in   = ext2(req.sample_value);
   assign inmask  = !req.mask_applies || !control_ff[sovc_pkg::CTL_MASK_ON] ||
                    (req.mask_bit != control_ff[sovc_pkg::CTL_MASK_INV]);
   assign hit_pos = (d2_in >= min2 + off2) && !(inv && trunc);
   assign hit_neg = (d2_in <= off2 - min2) && !(trunc && !inv);
   assign painted1_in = (method != sovc_pkg::METHOD_NONE) && inmask && (hit_pos || hit_neg);
   assign in_low  = hit_pos ? (d2_in < mid2 + off2) : (d2_in >= off2 - mid2);
   assign in_high = hit_pos ? (d2_in <= max2 + off2) : (d2_in >= off2 - max2);

   always_comb begin
      if (method == sovc_pkg::METHOD_OPAQUE) seg_in = sovc_pkg::SEG_HIGH;
      else if (in_low)                       seg_in = sovc_pkg::SEG_LOW;
      else if (in_high)                      seg_in = sovc_pkg::SEG_HIGH;
      else                                   seg_in = sovc_pkg::SEG_HOLD;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d2_ff       <= d2_in;
         pos_ff      <= hit_pos;
         swap_ff     <= hit_pos ? inv : !inv;
         painted1_ff <= painted1_in;
         seg_ff      <= seg_in;
         base1_ff    <= {req.base_blue, req.base_green, req.base_red};
         op1_ff      <= (opacity_ff > sovc_pkg::OPACITY_FULL) ? sovc_pkg::OPACITY_FULL
                                                             : opacity_ff;
      end
   end

   // stage 2: ratio terms and colour selection
   logic signed [NW-1:0] sd, num_in, den_in, num_ff, den_ff;
   sovc_pkg::rgb_type    lo, hi, a_in, b_in;
   sovc_pkg::pix_type    pix2_ff;

   assign sd = pos_ff ? -d2_ff : d2_ff;
   assign lo = unpack(low_ff, swap_ff);
   assign hi = unpack(high_ff, swap_ff);

   always_comb begin
      case (seg_ff)
         sovc_pkg::SEG_LOW: begin
            num_in = mid2 + off2 + sd;
            den_in = mid2 - min2;
            a_in   = base1_ff;
            b_in   = lo;
         end
         sovc_pkg::SEG_HIGH: begin
            num_in = max2 + off2 + sd;
            den_in = max2 - mid2;
            a_in   = lo;
            b_in   = hi;
         end
         default: begin
            num_in = '0;
            den_in = NW'(1);
            a_in   = hi;
            b_in   = hi;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         num_ff          <= num_in;
         den_ff          <= den_in;
         pix2_ff.a       <= a_in;
         pix2_ff.b       <= b_in;
         pix2_ff.base    <= base1_ff;
         pix2_ff.op      <= op1_ff;
         pix2_ff.painted <= painted1_ff;
         pix2_ff.full    <= 1'b0;
      end
   end

   // stage 3: sign fix and clamp
   logic signed [NW-1:0] nn, dn;
   logic                 full_in;
   logic [NW-1:0]        rem_in;
   sovc_pkg::pix_type    pix3_in;
   always_comb begin
      nn = num_ff;
      dn = den_ff;
      if (den_ff < 0) begin
         nn = -num_ff;
         dn = -den_ff;
      end
      if (dn == 0) begin
         nn = '0;
         dn = NW'(1);
      end
      full_in = (nn > 0) && (nn >= dn);
      rem_in  = (nn <= 0 || full_in) ? '0 : nn;
      pix3_in      = pix2_ff;
      pix3_in.full = full_in;
   end

   logic [NW-1:0]             rem_ff [ND+1];
   logic [NW-1:0]             dv_ff  [ND+1];
   logic [sovc_pkg::Q_BITS-1:0] q_ff [ND+1];
   sovc_pkg::pix_type         pix_ff [ND+1];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         rem_ff[0] <= rem_in;
         dv_ff[0]  <= dn;
         q_ff[0]   <= '0;
         pix_ff[0] <= pix3_in;
      end
   end

   // divider stages
   for (genvar g = 0; g < ND; g++) begin : g_div
      logic [NW-1:0]             rem_nx;
      logic [sovc_pkg::Q_BITS-1:0] q_nx;
      sovc_div_step #(.WIDTH(NW)) u_step (
         .rem_in (rem_ff[g]),
         .den    (dv_ff[g]),
         .q_in   (q_ff[g]),
         .rem_out(rem_nx),
         .q_out  (q_nx)
      );
      always_ff @(posedge clock) begin
         if (en[g+3]) begin
            rem_ff[g+1] <= rem_nx;
            dv_ff[g+1]  <= dv_ff[g];
            q_ff[g+1]   <= q_nx;
            pix_ff[g+1] <= pix_ff[g];
         end
      end
   end

   // multiply stage 1: colour ramp
   logic [sovc_pkg::Q_BITS:0] rq;
   sovc_pkg::pix_type         pm_ff;
   logic [39:0]               ramp_ff [3];
   logic [16:0]               bterm_ff [3];
   assign rq = pix_ff[ND].full ? {1'b1, {sovc_pkg::Q_BITS{1'b0}}} : {1'b0, q_ff[ND]};

   always_ff @(posedge clock) begin
      if (en[ND+3]) begin
         pm_ff <= pix_ff[ND];
         for (int c = 0; c < 3; c++) begin
            ramp_ff[c]  <= 40'(pix_ff[ND].a[c] * rq +
                               pix_ff[ND].b[c] * ({1'b1, {sovc_pkg::Q_BITS{1'b0}}} - rq));
            bterm_ff[c] <= 17'(pix_ff[ND].base[c] * (sovc_pkg::OPACITY_FULL - pix_ff[ND].op));
         end
      end
   end

   // multiply stage 2: opacity blend into the output register
   sovc_pkg::rgb_type out_in, out_ff;
   logic              painted_ff;
   always_comb begin
      logic [48:0] t;
      for (int c = 0; c < 3; c++) begin
         t = {bterm_ff[c], 32'b0} + 49'(ramp_ff[c] * pm_ff.op);
         out_in[c] = pm_ff.painted ? t[47:40] : pm_ff.base[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ND+4]) begin
         out_ff     <= out_in;
         painted_ff <= pm_ff.painted;
      end
   end

   assign rsp.valid     = valid_ff[NS-1];
   assign rsp.out_red   = out_ff[0];
   assign rsp.out_green = out_ff[1];
   assign rsp.out_blue  = out_ff[2];
   assign rsp.painted   = painted_ff;
endmodule

// File: rtl/sovc_div_step.sv
// sovc_div_step: DIV_STEP restoring division steps for the ramp ratio
// uses sovc_pkg
module sovc_div_step #(
   parameter int WIDTH = 36
) (
   input  logic [WIDTH-1:0]          rem_in,
   input  logic [WIDTH-1:0]          den,
   input  logic [sovc_pkg::Q_BITS-1:0] q_in,
   output logic [WIDTH-1:0]          rem_out,
   output logic [sovc_pkg::Q_BITS-1:0] q_out
);
   always_comb begin
      logic [WIDTH:0]             r;
      logic [sovc_pkg::Q_BITS-1:0] q;
      r = {1'b0, rem_in};
      q = q_in;
      for (int i = 0; i < sovc_pkg::DIV_STEP; i++) begin
         r = {r[WIDTH-1:0], 1'b0};
         q = {q[sovc_pkg::Q_BITS-2:0], 1'b0};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[0] = 1'b1;
         end
      end
      rem_out = r[WIDTH-1:0];
      q_out   = q;
   end
endmodule

// File: rtl/sovc_checker.sv
// sovc_checker: port-level assertions of the colormap, bound to the top level
// depends on symmetric_overlay_colormap ports
module sovc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue,
   input logic       rsp_painted
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input refused while output drains");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_out_red, rsp_out_green, rsp_out_blue,
                                           rsp_painted}))
      else $error("result changed under stall");
endmodule

bind symmetric_overlay_colormap sovc_checker u_sovc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_out_red  (rsp.out_red),
   .rsp_out_green(rsp.out_green),
   .rsp_out_blue (rsp.out_blue),
   .rsp_painted  (rsp.painted)
);

// File: test/symmetric_overlay_colormap_tb.sv
// symmetric_overlay_colormap_tb: self-checking bench for the overlay colormap
// depends on sovc_pkg, sovc_if and the symmetric_overlay_colormap rtl
// a scoreboard predicts each vertex colour and checks responses in order
`timescale 1ns / 1ps

typedef struct {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       painted;
} vertex_colour_type;

class colormap_scoreboard;
   logic [31:0] min_pt, mid_pt, max_pt, offset;
   logic [8:0]  opacity;
   logic [23:0] low_col, high_col;
   logic [5:0]  control;
   vertex_colour_type colour_q[$];
   int errors;

   function new();
      min_pt = 0; mid_pt = 0; max_pt = 32'd65536; offset = 0;
      opacity = sovc_pkg::OPACITY_FULL; low_col = 24'hFF0000; high_col = 24'hFFFF00;
      control = 0; errors = 0;
   endfunction

   function void write_reg(sovc_pkg::csr_index_type idx, logic [31:0] data);
      case (idx)
         sovc_pkg::CSR_MIN_POINT:    min_pt = data;
         sovc_pkg::CSR_MID_POINT:    mid_pt = data;
         sovc_pkg::CSR_MAX_POINT:    max_pt = data;
         sovc_pkg::CSR_VALUE_OFFSET: offset = data;
         sovc_pkg::CSR_OPACITY:      opacity = data[8:0];
         sovc_pkg::CSR_LOW_COLOUR:   low_col = data[23:0];
         sovc_pkg::CSR_HIGH_COLOUR:  high_col = data[23:0];
         sovc_pkg::CSR_CONTROL:      control = data[5:0];
         default: ;
      endcase
   endfunction

   function sovc_pkg::rgb_type channels(logic [23:0] c, bit swap);
      sovc_pkg::rgb_type ch;
      ch[0] = swap ? c[7:0] : c[23:16];
      ch[1] = c[15:8];
      ch[2] = swap ? c[23:16] : c[7:0];
      return ch;
   endfunction

   function sovc_pkg::rgb_type ramp_blend(longint num, longint den, sovc_pkg::rgb_type a,
                                          sovc_pkg::rgb_type b, sovc_pkg::rgb_type base,
                                          longint unsigned op);
      longint unsigned frac, rem, dv, t;
      sovc_pkg::rgb_type res;
      frac = 0;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (den == 0) begin
         num = 0;
         den = 1;
      end
      if (num <= 0) frac = 0;
      else if (num >= den) frac = 64'd1 << 32;
      else begin
         rem = num;
         dv = den;
         for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= dv) begin
               rem -= dv;
               frac |= 1;
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         t = 64'(base[i]) * (256 - op) * (64'd1 << 32)
             + (64'(a[i]) * frac + 64'(b[i]) * ((64'd1 << 32) - frac)) * op;
         res[i] = t[47:40];
      end
      return res;
   endfunction

   function void note_vertex(logic [31:0] sample, logic [7:0] br, logic [7:0] bg,
                             logic [7:0] bb, logic mbit, logic mapplies);
      sovc_pkg::method_type method;
      bit inv, trunc, mon, minv, inmask, paint, pos, swap, in_low, in_high;
      longint d2, min2, max2, off2, mid2, sd;
      longint unsigned op;
      sovc_pkg::rgb_type base, res, lo, hi;
      vertex_colour_type exp_col;
      method = sovc_pkg::method_type'(control[1:0]);
      inv = control[sovc_pkg::CTL_INVERSE];
      trunc = control[sovc_pkg::CTL_TRUNCATE];
      mon = control[sovc_pkg::CTL_MASK_ON];
      minv = control[sovc_pkg::CTL_MASK_INV];
      op = (opacity > sovc_pkg::OPACITY_FULL) ? 256 : opacity;
      d2 = 2 * longint'(signed'(sample));
      min2 = 2 * longint'(signed'(min_pt));
      max2 = 2 * longint'(signed'(max_pt));
      off2 = 2 * longint'(signed'(offset));
      mid2 = (method == sovc_pkg::METHOD_PIECEWISE) ? 2 * longint'(signed'(mid_pt))
             : longint'(signed'(max_pt)) + longint'(signed'(min_pt));
      base[0] = br; base[1] = bg; base[2] = bb;
      res = base;
      inmask = 1;
      paint = 0; pos = 0; swap = 0;
      if (mapplies) inmask = !mon || (mbit != minv);
      if (method != sovc_pkg::METHOD_NONE && inmask) begin
         if (d2 >= min2 + off2 && !(inv && trunc)) begin
            paint = 1; pos = 1; swap = inv;
         end else if (d2 <= -min2 + off2 && !(trunc && !inv)) begin
            paint = 1; pos = 0; swap = !inv;
         end
      end
      if (paint) begin
         sd = pos ? -d2 : d2;
         lo = channels(low_col, swap);
         hi = channels(high_col, swap);
         if (method == sovc_pkg::METHOD_OPAQUE) begin
            res = ramp_blend(max2 + off2 + sd, max2 - mid2, lo, hi, base, op);
         end else begin
            in_low = pos ? (d2 < mid2 + off2) : (d2 >= -mid2 + off2);
            in_high = pos ? (d2 <= max2 + off2) : (d2 >= -max2 + off2);
            if (in_low) res = ramp_blend(mid2 + off2 + sd, mid2 - min2, base, lo, base, op);
            else if (in_high) res = ramp_blend(max2 + off2 + sd, max2 - mid2, lo, hi, base, op);
            else res = ramp_blend(0, 1, hi, hi, base, op);
         end
      end
      exp_col.red = res[0];
      exp_col.green = res[1];
      exp_col.blue = res[2];
      exp_col.painted = paint;
      colour_q.push_back(exp_col);
   endfunction

   function void check_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic p);
      vertex_colour_type e;
      if (colour_q.size() == 0) begin
         $error("unexpected response transaction");
         errors++;
         return;
      end
      e = colour_q.pop_front();
      if (r !== e.red) begin
         $error("out_red expected %0d actual %0d", e.red, r);
         errors++;
      end
      if (g !== e.green) begin
         $error("out_green expected %0d actual %0d", e.green, g);
         errors++;
      end
      if (b !== e.blue) begin
         $error("out_blue expected %0d actual %0d", e.blue, b);
         errors++;
      end
      if (p !== e.painted) begin
         $error("painted expected %0d actual %0d", e.painted, p);
         errors++;
      end
   endfunction
endclass

module symmetric_overlay_colormap_tb;
   localparam int LIMIT = 1000000;
   localparam int LATENCY = 13;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_wr_data = 0;
   int          cycles = 0;
   bit          req_taken = 0;
   bit          calm = 0;
   colormap_scoreboard sb = new();

   sovc_req_if #(.VALUE_WIDTH(32)) req();
   sovc_rsp_if rsp();

   symmetric_overlay_colormap #(.VALUE_WIDTH(32), .FRACTION_BITS(16)) i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req.valid = 0; req.sample_value = 0; req.base_red = 0; req.base_green = 0;
      req.base_blue = 0; req.mask_bit = 0; req.mask_applies = 0;
      rsp.ready = 0;
   end

   function automatic int gap_len();
      if (calm || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // transaction monitor
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("symmetric_overlay_colormap_tb: done, errors");
         $finish;
      end
      req_taken = !reset && req.valid && req.ready;
      if (req_taken)
         sb.note_vertex(req.sample_value, req.base_red, req.base_green, req.base_blue,
                        req.mask_bit, req.mask_applies);
      if (!reset && rsp.valid && rsp.ready)
         sb.check_colour(rsp.out_red, rsp.out_green, rsp.out_blue, rsp.painted);
   end

   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp.ready = 0;
      end else begin
         stall_left = gap_len();
         rsp.ready = (stall_left == 0);
      end
   end

   task automatic send_vertex(logic [31:0] v, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b, logic mb, logic ma);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req.valid = 1;
      req.sample_value = v; req.base_red = r; req.base_green = g;
      req.base_blue = b; req.mask_bit = mb; req.mask_applies = ma;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic send_random_vertex();
      longint c;
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: c = longint'(signed'(sb.min_pt));
         1: c = -longint'(signed'(sb.min_pt));
         2: c = longint'(signed'(sb.mid_pt));
         3: c = -longint'(signed'(sb.mid_pt));
         4: c = longint'(signed'(sb.max_pt));
         5: c = -longint'(signed'(sb.max_pt));
         default: c = 0;
      endcase
      c += longint'(signed'(sb.offset));
      if ($urandom_range(0, 1)) c += longint'($urandom_range(0, 6)) - 3;
      else c += longint'($urandom_range(0, 65536)) - 32768;
      v = c[31:0];
      if ($urandom_range(0, 4) == 0) v = $urandom;
      send_vertex(v, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom));
   endtask

   task automatic wait_idle();
      req.valid = 0;
      do @(negedge clock); while (sb.colour_q.size() != 0);
      repeat (LATENCY + 3) @(negedge clock);
   endtask

   task automatic csr_write(sovc_pkg::csr_index_type idx, logic [31:0] data);
      csr_wr_en = 1;
      csr_index = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 0;
      sb.write_reg(idx, data);
   endtask

   function automatic logic [31:0] pick_point();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 0;
         default: return $urandom_range(0, 524288) - 262144;
      endcase
   endfunction

   task automatic load_setting(int kind);
      logic [31:0] mn, mx;
      mn = $urandom_range(0, 131072);
      mx = mn + $urandom_range(0, 262144);
      case (kind)
         0: begin
            mn = 32'h8000_0000; mx = 32'h7FFF_FFFF;
         end
         1: mx = mn;
         2: begin
            mn = pick_point(); mx = pick_point();
         end
         default: ;
      endcase
      csr_write(sovc_pkg::CSR_MIN_POINT, mn);
      csr_write(sovc_pkg::CSR_MAX_POINT, mx);
      csr_write(sovc_pkg::CSR_MID_POINT, (kind == 2) ? pick_point()
                : mn + $urandom_range(0, mx - mn));
      csr_write(sovc_pkg::CSR_VALUE_OFFSET, (kind == 0) ? 32'hFFFF_FFFF
                : ($urandom_range(0, 3) == 0 ? pick_point() : $urandom_range(0, 8192) - 4096));
      case ($urandom_range(0, 4))
         0: csr_write(sovc_pkg::CSR_OPACITY, 32'd0);
         1: csr_write(sovc_pkg::CSR_OPACITY, 32'h1FF);
         2: csr_write(sovc_pkg::CSR_OPACITY, 32'(sovc_pkg::OPACITY_FULL));
         default: csr_write(sovc_pkg::CSR_OPACITY, $urandom_range(0, 511));
      endcase
      csr_write(sovc_pkg::CSR_LOW_COLOUR, (kind == 0) ? 32'h000000 : $urandom);
      csr_write(sovc_pkg::CSR_HIGH_COLOUR, (kind == 0) ? 32'hFFFFFF : $urandom);
      csr_write(sovc_pkg::CSR_CONTROL, $urandom_range(0, 63));
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 0;
      // reset settings: extremes and mask combinations
      send_vertex(32'h0000_0000, 8'h00, 8'h00, 8'h00, 0, 0);
      send_vertex(32'h7FFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1, 1);
      send_vertex(32'h8000_0000, 8'hFF, 8'h00, 8'hFF, 0, 1);
      send_vertex(32'h0001_0000, 8'h80, 8'h40, 8'h20, 1, 0);
      send_vertex(32'hFFFF_0000, 8'h10, 8'h20, 8'h30, 0, 1);
      send_vertex(32'h0000_8000, 8'h7F, 8'h01, 8'hFE, 1, 1);
      send_vertex(32'hFFFF_8000, 8'h01, 8'hFE, 8'h7F, 0, 0);
      send_vertex(32'h0002_0000, 8'hAA, 8'h55, 8'hAA, 1, 0);
      send_vertex(32'hFFFE_0000, 8'h55, 8'hAA, 8'h55, 0, 1);
      wait_idle();
      for (int m = 0; m < 4; m++) begin
         load_setting(m == 3 ? 0 : 3);
         csr_write(sovc_pkg::CSR_CONTROL, (m == 3) ? 32'd0 : 32'(m | (m << 2) | 6'h10));
         send_vertex(32'h0000_0000, 8'h00, 8'hFF, 8'h00, 0, 1);
         send_vertex(32'h7FFF_FFFF, 8'hFF, 8'h00, 8'hFF, 1, 1);
         send_vertex(32'h8000_0000, 8'h33, 8'h66, 8'h99, 1, 0);
         send_random_vertex();
         wait_idle();
      end
      for (int ph = 0; ph < 20; ph++) begin
         calm = (ph % 5 == 4);
         load_setting($urandom_range(0, 5));
         repeat (50) send_random_vertex();
         wait_idle();
      end
      calm = 0;
      req.valid = 0;
      do @(negedge clock); while (sb.colour_q.size() != 0);
      repeat (LATENCY * 2) @(negedge clock);
      if (sb.errors == 0)
         $display("symmetric_overlay_colormap_tb: done, clean");
      else
         $display("symmetric_overlay_colormap_tb: done, errors");
      $finish;
   end
endmodule
